// ===== rtl/core/chdc_pkg.sv =====
// Shared types, constants and the seed chain for the character hash digest check.
package chdc_pkg;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned WordW     = 16;
  localparam int unsigned DigestW   = 32;
  localparam int unsigned NumDigest = 8;
  localparam int unsigned RefW      = 64;
  localparam int unsigned NumRefs   = 4;
  localparam int unsigned MacRot    = 5;
  localparam int unsigned DigestRot = 5;

  localparam logic [WordW-1:0] SeedFirst = 16'h6c69;
  localparam logic [WordW-1:0] SeedMul   = 16'h9E37;

  typedef logic [WordW-1:0] word_t;

  // Seed chain: w[0] = SeedFirst, w[i] = w[i-1] * SeedMul + i (mod 2^16).
  function automatic logic [NumWords-1:0][WordW-1:0] seed_chain();
    logic [NumWords-1:0][WordW-1:0] s;
    logic [31:0]                    p;
    s[0] = SeedFirst;
    for (int i = 1; i < NumWords; i++) begin
      p    = 32'(s[i-1]) * 32'(SeedMul) + 32'(i);
      s[i] = p[WordW-1:0];
    end
    return s;
  endfunction

  localparam logic [NumWords-1:0][WordW-1:0] SeedWords = seed_chain();

  // Operation of the shared mixing unit.
  typedef enum logic {
    UNIT_MIX = 1'b0,
    UNIT_MAC = 1'b1
  } unit_op_e;

  // Update applied to the word ring when it registers its next state.
  typedef enum logic [2:0] {
    RING_HOLD   = 3'd0,
    RING_SHIFT1 = 3'd1,
    RING_SHIFT4 = 3'd2,
    RING_DROP   = 3'd3,
    RING_SEED   = 3'd4
  } ring_op_e;

  typedef struct packed {
    ring_op_e op;
    word_t    mix_word;
    word_t    mac_first;
    word_t    mac_fourth;
  } ring_ctrl_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    word_t w7;
    word_t w8;
  } ring_taps_t;

endpackage

// ===== rtl/core/chdc_mix_unit.sv =====
// Shared mixing unit: xor/shift scramble, one rotator, 16x16 multiply-add.
module chdc_mix_unit (
  input  chdc_pkg::unit_op_e op_i,
  input  chdc_pkg::ring_taps_t taps_i,
  input  chdc_pkg::word_t    char_i,
  input  logic [3:0]         rot_amt_i,
  output chdc_pkg::word_t    main_o,
  output chdc_pkg::word_t    rot_o
);

  chdc_pkg::word_t x;
  chdc_pkg::word_t scr;
  chdc_pkg::word_t rot_in;
  logic [3:0]      amt;
  logic [31:0]     rot_wide;
  logic [31:0]     prod;
  logic [15:0]     mac_sum;

  assign x   = taps_i.w0 ^ char_i;
  assign scr = x ^ ((x >> 4) ^ (x << 3) ^ (x << 7) ^ (x >> 8));

  // One rotator serves both passes.
  assign rot_in   = (op_i == chdc_pkg::UNIT_MIX) ? scr : taps_i.w3;
  assign amt      = (op_i == chdc_pkg::UNIT_MIX) ? rot_amt_i : 4'(chdc_pkg::MacRot);
  assign rot_wide = {rot_in, rot_in} << amt;
  assign rot_o    = rot_wide[31:16];

  assign prod    = 32'(taps_i.w2) * 32'(taps_i.w3);
  assign mac_sum = (taps_i.w0 ^ taps_i.w1) + prod[15:0];

  assign main_o = (op_i == chdc_pkg::UNIT_MIX) ? (rot_o ^ taps_i.w7) : mac_sum;

endmodule

// ===== rtl/core/chdc_word_ring.sv =====
// Sixteen-word hash state held as a rotating ring with fixed read taps.
module chdc_word_ring (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chdc_pkg::ring_ctrl_t ctrl_i,
  output chdc_pkg::ring_taps_t taps_o
);

  chdc_pkg::word_t ring_q [chdc_pkg::NumWords];
  chdc_pkg::word_t ring_d [chdc_pkg::NumWords];

  always_comb begin
    for (int k = 0; k < chdc_pkg::NumWords; k++) begin
      ring_d[k] = ring_q[k];
    end
    case (ctrl_i.op)
      chdc_pkg::RING_SHIFT1: begin
        // Advance one word; the fresh word enters at the tail.
        for (int k = 0; k < chdc_pkg::NumWords - 1; k++) begin
          ring_d[k] = ring_q[k+1];
        end
        ring_d[chdc_pkg::NumWords-1] = ctrl_i.mix_word;
      end
      chdc_pkg::RING_SHIFT4: begin
        // Advance one group of four; the updated group enters at the tail.
        for (int k = 0; k < chdc_pkg::NumWords - 4; k++) begin
          ring_d[k] = ring_q[k+4];
        end
        ring_d[chdc_pkg::NumWords-4] = ctrl_i.mac_first;
        ring_d[chdc_pkg::NumWords-3] = ring_q[1];
        ring_d[chdc_pkg::NumWords-2] = ring_q[2];
        ring_d[chdc_pkg::NumWords-1] = ctrl_i.mac_fourth;
      end
      chdc_pkg::RING_DROP: begin
        for (int k = 0; k < chdc_pkg::NumWords - 1; k++) begin
          ring_d[k] = ring_q[k+1];
        end
        ring_d[chdc_pkg::NumWords-1] = ring_q[0];
      end
      chdc_pkg::RING_SEED: begin
        for (int k = 0; k < chdc_pkg::NumWords; k++) begin
          ring_d[k] = chdc_pkg::SeedWords[k];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < chdc_pkg::NumWords; k++) begin
        ring_q[k] <= chdc_pkg::SeedWords[k];
      end
    end else begin
      for (int k = 0; k < chdc_pkg::NumWords; k++) begin
        ring_q[k] <= ring_d[k];
      end
    end
  end

  assign taps_o.w0 = ring_q[0];
  assign taps_o.w1 = ring_q[1];
  assign taps_o.w2 = ring_q[2];
  assign taps_o.w3 = ring_q[3];
  assign taps_o.w7 = ring_q[7];
  assign taps_o.w8 = ring_q[8];

endmodule

// ===== rtl/core/char_hash_digest_check.sv =====
// Top level: character hash absorber with digest output and reference compare.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready tdata[15:0] character, tlast last_char
//  m_axis    out        m_axis_tvalid/m_axis_tready tdata[31:0] digest_word,
//                                                   tdata[34:32] word_index,
//                                                   tlast last_word, tuser match
//  cfg       in         cfg_we_i                    cfg_idx_i register, cfg_data_i value
//
//  Each character passes through the shared mixing unit as 16 word updates
//  (one ring step each) followed by 4 multiply-add groups; the block is not
//  ready during that time and takes no new character until it is through with
//  the last one. A final character then emits 8 digest items, one
//  per cycle while m_axis_tready is high, and the state is reseeded on the
//  last one. Reset loads the seed chain and clears the reference registers.
module char_hash_digest_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] character
  input  logic        s_axis_tlast,   // last_char
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast,   // last_word
  output logic        m_axis_tuser,   // match
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]                 cnt_q, cnt_d;
  chdc_pkg::word_t            char_q;
  logic                       last_q;
  logic                       diff_q, diff_d;
  logic [chdc_pkg::RefW-1:0]  ref_q [chdc_pkg::NumRefs];

  chdc_pkg::ring_ctrl_t ring_ctrl;
  chdc_pkg::ring_taps_t taps;
  chdc_pkg::unit_op_e   unit_op;
  chdc_pkg::word_t      unit_main;
  chdc_pkg::word_t      unit_rot;

  logic                           in_acc;
  logic                           out_acc;
  logic [chdc_pkg::DigestW-1:0]   joined;
  logic [chdc_pkg::DigestW-1:0]   digest;
  logic [chdc_pkg::RefW-1:0]      ref_pair;
  logic [chdc_pkg::DigestW-1:0]   ref_word;
  logic                           word_neq;
  logic [2:0]                     word_idx;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Shared unit works on the ring head; rotate amount is the word position.
  assign unit_op = (state_q == ST_MAC) ? chdc_pkg::UNIT_MAC : chdc_pkg::UNIT_MIX;

  chdc_mix_unit u_mix (
    .op_i      (unit_op),
    .taps_i    (taps),
    .char_i    (char_q),
    .rot_amt_i (cnt_q),
    .main_o    (unit_main),
    .rot_o     (unit_rot)
  );

  chdc_word_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .taps_o (taps)
  );

  // Digest word i joins words i and i+8, which sit at ring taps 0 and 8 while
  // the ring steps one word per emitted item.
  assign word_idx = cnt_q[2:0];
  assign joined   = {taps.w0, taps.w8};
  assign digest   = {joined[chdc_pkg::DigestW-1-chdc_pkg::DigestRot:0],
                     joined[chdc_pkg::DigestW-1:chdc_pkg::DigestW-chdc_pkg::DigestRot]};
  assign ref_pair = ref_q[word_idx[2:1]];
  assign ref_word = word_idx[0] ? ref_pair[31:0] : ref_pair[63:32];
  assign word_neq = |(digest ^ ref_word);

  always_comb begin
    state_d              = state_q;
    cnt_d                = cnt_q;
    diff_d               = diff_q;
    ring_ctrl.op         = chdc_pkg::RING_HOLD;
    ring_ctrl.mix_word   = unit_main;
    ring_ctrl.mac_first  = unit_main;
    ring_ctrl.mac_fourth = unit_rot;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MIX;
          cnt_d   = '0;
        end
      end
      ST_MIX: begin
        ring_ctrl.op = chdc_pkg::RING_SHIFT1;
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == 4'(chdc_pkg::NumWords - 1)) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        ring_ctrl.op = chdc_pkg::RING_SHIFT4;
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q == 4'(chdc_pkg::NumWords / 4 - 1)) begin
          cnt_d   = '0;
          diff_d  = 1'b0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          ring_ctrl.op = chdc_pkg::RING_DROP;
          diff_d       = diff_q | word_neq;
          cnt_d        = cnt_q + 4'd1;
          if (cnt_q == 4'(chdc_pkg::NumDigest - 1)) begin
            // Digest done: reload the seed chain for the next message.
            ring_ctrl.op = chdc_pkg::RING_SEED;
            cnt_d        = '0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      diff_q  <= 1'b0;
      last_q  <= 1'b0;
      for (int k = 0; k < chdc_pkg::NumRefs; k++) begin
        ref_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      diff_q  <= diff_d;
      if (in_acc) begin
        last_q <= s_axis_tlast;
      end
      if (cfg_we_i) begin
        ref_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // Hold the character for the whole pass.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= s_axis_tdata;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {5'd0, word_idx, digest};
  assign m_axis_tlast  = (word_idx == 3'(chdc_pkg::NumDigest - 1));
  // Match covers every byte of every word, so its timing is data independent.
  assign m_axis_tuser  = m_axis_tlast && !(diff_q || word_neq);

endmodule

// ===== sim/tb_char_hash_digest_check.sv =====
// Self-checking bench for char_hash_digest_check: digest words and match flag against a predictor.
module tb_char_hash_digest_check;
  timeunit 1ns;
  timeprecision 1ps;

  import chdc_pkg::*;

  // Cycles a character spends in the mixing unit, with margin; also the quiet
  // time before touching the reference registers.
  localparam int unsigned SettleCycles = 40;
  // Length of the long output hold-off that backs the block up.
  localparam int unsigned HoldCycles   = 400;
  // Hard stop; far above the slowest correct run.
  localparam int unsigned CycleLimit   = 200_000;
  // Items per random phase.
  localparam int unsigned PhaseItems   = 16;

  typedef logic [DigestW-1:0] dword_t;
  typedef dword_t             digest_set_t [NumDigest];
  typedef logic [RefW-1:0]    ref_set_t    [NumRefs];

  typedef struct {
    dword_t     word;
    logic [2:0] index;
    logic       last_word;
    logic       match;
  } digest_rec_t;

  // Tracks the hash state and reference, and holds the digest words still owed.
  class digest_tracker;
    word_t       words [NumWords];
    ref_set_t    refs;
    digest_rec_t owed_q[$];
    int unsigned errors;

    function new();
      foreach (refs[k]) refs[k] = '0;
      errors = 0;
      reseed();
    endfunction

    function void reseed();
      words[0] = SeedFirst;
      for (int i = 1; i < NumWords; i++) words[i] = words[i-1] * SeedMul + word_t'(i);
    endfunction

    function word_t rotl(word_t v, int unsigned n);
      if (n == 0) return v;
      return (v << n) | (v >> (WordW - n));
    endfunction

    function void absorb(word_t c);
      word_t x;
      // Sequential pass: later words see the already updated earlier ones.
      for (int unsigned j = 0; j < NumWords; j++) begin
        x        = words[j] ^ c;
        x        = x ^ (x >> 4) ^ (x << 3) ^ (x << 7) ^ (x >> 8);
        words[j] = rotl(x, j) ^ words[(j + 7) % NumWords];
      end
      // Multiply-add groups; the fourth word rotates after its product is used.
      for (int unsigned g = 0; g < NumWords; g += 4) begin
        words[g]   = (words[g] ^ words[g+1]) + words[g+2] * words[g+3];
        words[g+3] = rotl(words[g+3], MacRot);
      end
    endfunction

    function void digest_words(output digest_set_t d);
      dword_t h;
      for (int i = 0; i < NumDigest; i++) begin
        h    = {words[i], words[i+8]};
        d[i] = (h << DigestRot) | (h >> (DigestW - DigestRot));
      end
    endfunction

    function void set_ref(int unsigned k, logic [RefW-1:0] v);
      refs[k] = v;
    endfunction

    // Reference value that a message would hit, taken from the seed state.
    function ref_set_t refs_for(word_t msg[$]);
      word_t       saved [NumWords];
      digest_set_t d;
      ref_set_t    r;
      saved = words;
      reseed();
      foreach (msg[k]) absorb(msg[k]);
      digest_words(d);
      for (int k = 0; k < NumRefs; k++) r[k] = {d[2*k], d[2*k+1]};
      words = saved;
      return r;
    endfunction

    function void note_char(word_t c, logic is_last);
      digest_set_t d;
      dword_t      ref_word;
      logic        all_equal;
      digest_rec_t e;
      absorb(c);
      if (!is_last) return;
      digest_words(d);
      all_equal = 1'b1;
      for (int i = 0; i < NumDigest; i++) begin
        ref_word = i[0] ? refs[i/2][31:0] : refs[i/2][63:32];
        if (d[i] != ref_word) all_equal = 1'b0;
      end
      for (int i = 0; i < NumDigest; i++) begin
        e.word      = d[i];
        e.index     = 3'(i);
        e.last_word = (i == NumDigest - 1);
        e.match     = (i == NumDigest - 1) && all_equal;
        owed_q.push_back(e);
      end
      reseed();
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction

    function void check(dword_t word, logic [2:0] index, logic last_word, logic match);
      digest_rec_t e;
      if (owed_q.size() == 0) begin
        $error("digest item with none owed: word %h index %0d", word, index);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (word != e.word) begin
        $error("digest_word: expected %h, got %h", e.word, word);
        errors++;
      end
      if (index != e.index) begin
        $error("word_index: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (last_word != e.last_word) begin
        $error("last_word: expected %0b, got %0b", e.last_word, last_word);
        errors++;
      end
      if (match != e.match) begin
        $error("match: expected %0b, got %0b", e.match, match);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] character
  logic        s_axis_tlast  = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] digest_word, [34:32] word_index
  logic        m_axis_tlast;         // last_word
  logic        m_axis_tuser;         // match
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [63:0] cfg_data_i    = '0;

  digest_tracker tracker;

  // Idling odds in percent, switched per phase.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic        hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  char_hash_digest_check u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: give up well past the slowest legal run.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: check each accepted digest item, then pick tready for the next
  // cycle. Values read right after the edge are the ones the edge sampled.
  initial begin : digest_sink
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        tracker.check(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast, m_axis_tuser);
      end
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one character, with random idle cycles ahead of it; return at the
  // edge that accepts it. Hold tvalid high when the caller sends again.
  task automatic send_char(word_t c, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.note_char(c, is_last);
  endtask

  task automatic send_message(word_t msg[$]);
    foreach (msg[k]) send_char(msg[k], k == msg.size() - 1);
  endtask

  // Mostly short messages, now and then a long one; characters mix full-range
  // values, printable ones and the extremes.
  task automatic send_random_message(inout int unsigned sent);
    word_t       msg[$];
    int unsigned len;
    int unsigned pick;
    len = ($urandom_range(9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 16);
    repeat (len) begin
      pick = $urandom_range(9);
      if (pick < 6)       msg.push_back(word_t'($urandom));
      else if (pick < 8)  msg.push_back(word_t'($urandom_range(16'h20, 16'h7e)));
      else if (pick == 8) msg.push_back(16'h0000);
      else                msg.push_back(16'hffff);
    end
    send_message(msg);
    sent += len;
  endtask

  // Drop tvalid and wait for every owed digest item, then let the block go idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four reference registers on consecutive edges.
  task automatic program_refs(ref_set_t v);
    for (int k = 0; k < NumRefs; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(k);
      cfg_data_i <= v[k];
      @(posedge clk_i);
      tracker.set_ref(k, v[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall);
    int unsigned sent;
    sent          = 0;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (sent < PhaseItems) send_random_message(sent);
    settle();
  endtask

  initial begin : stimulus
    word_t       probe_msg[$];
    ref_set_t    refs;
    int unsigned sent;

    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-character messages at both extremes, then one long
    // message walking through bit patterns, against the reset reference.
    send_message('{16'h0000});
    send_message('{16'hffff});
    send_message('{16'h8000, 16'h0001, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'hffff});
    settle();

    // Exact reference: the compare must report a match on the last word.
    probe_msg = '{16'h0041, 16'h0042, 16'h0043};
    refs      = tracker.refs_for(probe_msg);
    program_refs(refs);
    send_message(probe_msg);
    settle();

    // One bit off in the first byte, then in the last byte: no match either way.
    refs[0] ^= 64'h8000_0000_0000_0000;
    program_refs(refs);
    send_message(probe_msg);
    settle();
    refs[0] ^= 64'h8000_0000_0000_0000;
    refs[NumRefs-1] ^= 64'h1;
    program_refs(refs);
    send_message(probe_msg);
    settle();

    // Random traffic under each idling pattern, with a fresh reference each time.
    foreach (refs[k]) refs[k] = '1;
    program_refs(refs);
    random_phase(0, 0);

    foreach (refs[k]) refs[k] = {$urandom, $urandom};
    program_refs(refs);
    random_phase(63, 0);

    foreach (refs[k]) refs[k] = '0;
    program_refs(refs);
    random_phase(0, 63);

    foreach (refs[k]) refs[k] = 64'haaaa_aaaa_5555_5555;
    program_refs(refs);
    random_phase(35, 35);

    // Backpressure: the receiver holds off while messages keep coming, so the
    // output backs up and the input stalls. A random message whose digest was
    // programmed gets a match mixed into the traffic.
    probe_msg.delete();
    repeat ($urandom_range(1, 4)) probe_msg.push_back(word_t'($urandom));
    program_refs(tracker.refs_for(probe_msg));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b1;
    sent          = 0;
    send_message(probe_msg);
    while (sent < 12) send_random_message(sent);
    settle();

    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/chdc_pkg.sv
rtl/core/chdc_mix_unit.sv
rtl/core/chdc_word_ring.sv
rtl/core/char_hash_digest_check.sv
sim/tb_char_hash_digest_check.sv
